// File: rtl/core/alp_pkg.sv
`default_nettype none

package alp_pkg;

  // array limits
  localparam int unsigned MAX_DIMS     = 4;
  localparam int unsigned MAX_ELEMENTS = 4096;

  // field and register widths
  localparam int unsigned POS_W     = 12;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned NDIM_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 13;

  // derived widths
  localparam int unsigned ADDR_W    = $clog2(MAX_ELEMENTS);
  localparam int unsigned DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  // divider: quotient bits retired per cycle and cycles per digit
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_CYCLES = POS_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_COUNT    = 3'd0,
    CFG_TO_COL_MAJOR = 3'd1,
    CFG_ELEM_COUNT   = 3'd2,
    CFG_DIM_SIZE_0   = 3'd3,
    CFG_DIM_SIZE_1   = 3'd4,
    CFG_DIM_SIZE_2   = 3'd5,
    CFG_DIM_SIZE_3   = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ACC,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic mem_we;
    logic mem_re;
    logic resp_load;
  } ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/array_layout_permute.sv
// array layout permute: row-major <-> column-major reordering of a 4096 x 64-bit store
// input channel (in_valid_i/in_ready_o): command_i, position_i, element_word_i.
//   a write transaction stores element_word_i at position_i and gives no
//   result; writes may follow each other every cycle.
// a read transaction splits position_i into mixed-radix digits over the
//   configured extents, rebuilds the source position and returns the stored
//   word on the output channel (out_valid_o/out_ready_i).
// each digit runs through the shared restoring divider (four quotient bits a
//   cycle) and then a multiply-accumulate; after the last digit the store
//   is read and the word goes to the response register. an out-of-range read
//   skips the digit loop and the store read and returns zero with the flag set.
// one transaction at a time; a pending result sits in the output register so
//   a new transaction can be accepted while the receiver stalls, and the next
//   read waits only if the register is still full when its own result is ready.
// configuration (cfg_valid_i/cfg_ready_o) is always ready and must only be
//   written while the block is idle.
// reset clears control and configuration (one dimension of extent 1, element
//   count 1, column-major direction); the store is undefined until written.
`default_nettype none

module array_layout_permute (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [alp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire [alp_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // input transactions
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          command_i,
  input  wire [alp_pkg::POS_W-1:0]     position_i,
  input  wire [alp_pkg::WORD_W-1:0]    element_word_i,
  // result transactions
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [alp_pkg::WORD_W-1:0]   read_word_o,
  output logic                         out_of_range_o
);

  import alp_pkg::*;

  // configuration registers
  logic [NDIM_W-1:0]   dim_count_q;
  logic                to_col_major_q;
  logic [SIZE_W-1:0]   elem_count_q;
  logic [SIZE_W-1:0]   dim_size_q [MAX_DIMS];
  logic [CFG_IDX_W-1:0] dim_sel;

  // control and datapath
  state_e               state_q, state_d;
  ctrl_t                ctrl;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIM_IDX_W-1:0] k_q;
  logic [POS_W-1:0]     quo_q;
  logic [SIZE_W-1:0]    rem_q;
  logic [ADDR_W-1:0]    src_q;
  logic                 oor_q;

  logic [WORD_W-1:0]    store_q [MAX_ELEMENTS];
  logic [WORD_W-1:0]    rdata_q;

  logic                 out_valid_q;
  logic [WORD_W-1:0]    read_word_q;
  logic                 out_of_range_q;

  logic                 in_acc;
  logic                 rd_acc;
  logic                 pos_oor;
  logic [NDIM_W-1:0]    nd;
  logic [NDIM_W-1:0]    k_ext;
  logic [NDIM_W-1:0]    d_full;
  logic [SIZE_W-1:0]    sz;
  logic [SIZE_W-1:0]    divisor;
  logic                 last_div;
  logic                 last_digit;

  logic [SIZE_W:0]      div_t;
  logic [SIZE_W-1:0]    div_r;
  logic [POS_W-1:0]     div_q;

  logic [ADDR_W+SIZE_W-1:0] prod;
  logic [ADDR_W-1:0]        src_next;

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = ctrl.in_ready;
  assign out_valid_o    = out_valid_q;
  assign read_word_o    = read_word_q;
  assign out_of_range_o = out_of_range_q;

  assign in_acc  = in_valid_i && ctrl.in_ready;
  assign rd_acc  = in_acc && (command_i == CMD_READ);
  assign pos_oor = ({1'b0, position_i} >= elem_count_q);

  // effective dimension count and the extent of the current digit
  assign nd       = (dim_count_q > NDIM_W'(MAX_DIMS)) ? NDIM_W'(MAX_DIMS) : dim_count_q;
  assign k_ext    = NDIM_W'(k_q);
  assign d_full   = to_col_major_q ? k_ext : (nd - NDIM_W'(1) - k_ext);
  assign sz       = dim_size_q[d_full[DIM_IDX_W-1:0]];
  assign divisor  = (sz == '0) ? SIZE_W'(1) : sz;
  assign last_div   = (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1));
  assign last_digit = ((k_ext + NDIM_W'(1)) == nd);

  // restoring divider, DIV_STEPS quotient bits per cycle
  always_comb begin
    div_r = rem_q;
    div_q = quo_q;
    div_t = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      div_t = {div_r, div_q[POS_W-1]};
      div_q = {div_q[POS_W-2:0], 1'b0};
      if (div_t >= {1'b0, divisor}) begin
        div_t    = div_t - {1'b0, divisor};
        div_q[0] = 1'b1;
      end
      div_r = div_t[SIZE_W-1:0];
    end
  end

  // source position accumulate, wraps modulo the store depth
  assign prod     = {{SIZE_W{1'b0}}, src_q} * {{ADDR_W{1'b0}}, divisor};
  assign src_next = prod[ADDR_W-1:0] + rem_q[ADDR_W-1:0];

  // configuration writes
  assign dim_sel = cfg_index_i - CFG_DIM_SIZE_0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q    <= NDIM_W'(1);
      to_col_major_q <= 1'b1;
      elem_count_q   <= SIZE_W'(1);
      for (int i = 0; i < MAX_DIMS; i++) begin
        dim_size_q[i] <= SIZE_W'(1);
      end
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DIM_COUNT:    dim_count_q    <= cfg_data_i[NDIM_W-1:0];
        CFG_TO_COL_MAJOR: to_col_major_q <= cfg_data_i[0];
        CFG_ELEM_COUNT:   elem_count_q   <= cfg_data_i[SIZE_W-1:0];
        CFG_DIM_SIZE_0, CFG_DIM_SIZE_1, CFG_DIM_SIZE_2, CFG_DIM_SIZE_3: begin
          if (dim_sel < CFG_IDX_W'(MAX_DIMS)) begin
            dim_size_q[dim_sel[DIM_IDX_W-1:0]] <= cfg_data_i[SIZE_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (rd_acc) begin
          if (pos_oor) begin
            state_d = ST_RESP;
          end else if (nd == '0) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (last_div) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = last_digit ? ST_READ : ST_DIV;
      end
      ST_READ: state_d = ST_RESP;
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.mem_we   = in_valid_i && (command_i == CMD_WRITE);
      end
      ST_READ: ctrl.mem_re = 1'b1;
      ST_RESP: ctrl.resp_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.resp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // digit datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (rd_acc) begin
          quo_q <= position_i;
          rem_q <= '0;
          src_q <= '0;
          k_q   <= '0;
          cnt_q <= '0;
          oor_q <= pos_oor;
        end
      end
      ST_DIV: begin
        quo_q <= div_q;
        rem_q <= div_r;
        cnt_q <= cnt_q + DIV_CNT_W'(1);
      end
      ST_ACC: begin
        src_q <= src_next;
        rem_q <= '0;
        cnt_q <= '0;
        k_q   <= k_q + DIM_IDX_W'(1);
      end
      default: ;
    endcase
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (ctrl.resp_load) begin
      read_word_q    <= oor_q ? '0 : rdata_q;
      out_of_range_q <= oor_q;
    end
  end

  // element store, one write or one read a cycle
  always_ff @(posedge clk_i) begin
    if (ctrl.mem_we) begin
      store_q[position_i[ADDR_W-1:0]] <= element_word_i;
    end
    if (ctrl.mem_re) begin
      rdata_q <= store_q[src_q];
    end
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (read_word_o == '0))
    else $error("out-of-range result carries a non-zero word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_acc && pos_oor) |=> (state_q == ST_RESP) && oor_q)
    else $error("out-of-range read did not skip the digit loop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_ACC) |-> (rem_q < divisor) && (k_ext < nd))
    else $error("divider remainder or digit index out of bounds");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (command_i == CMD_WRITE)) |=> (state_q == ST_IDLE))
    else $error("write transaction left the idle state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_RESP) && !ctrl.mem_re)
    else $error("store read not followed by response");

endmodule

`default_nettype wire
